### src/sis_pkg.sv
// Package for the sorted index search block: field widths, command and
// status codes, and the item types of the request and result channels.
// No dependencies.
package sis_pkg;

	localparam int KEY_W = 64;
	localparam int OFF_W = 32;
	localparam int POS_W = 11;
	localparam int DEPTH_DEF = 1024;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_FIND   = 2'd2,
		MODE_LOWER  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [KEY_W-1:0]   search_key;
		logic [OFF_W-1:0]   offset_value;
		logic [POS_W-1:0]   range_start;
		logic [POS_W-1:0]   range_end;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [POS_W-1:0]   position;
		logic [OFF_W-1:0]   stored_offset;
	} rsp_t;

endpackage

### src/sis_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered
// read port. Used for the key and offset stores. No dependencies.
module sis_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### src/sis_seq.sv
// Command sequencer: entry count, append and clear, and the binary search
// that probes the key and offset stores one entry per cycle.
// Depends on sis_pkg and sis_ram.
module sis_seq import sis_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	input  logic room,
	output logic done,
	output rsp_t res
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_CMP,
		S_OFF,
		S_DONE
	} state_t;

	state_t           state_q;
	mode_t            mode_q;
	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hi_q;
	logic [CW-1:0]    end_q;
	logic [CW-1:0]    mid_q;
	rsp_t             res_q;

	logic             accept;
	logic             full;
	logic             wr_en;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [KEY_W-1:0] key_rd;
	logic [OFF_W-1:0] off_rd;
	logic             key_lt;
	logic             hit;
	logic             searching;
	logic             more;
	logic [CW-1:0]    cur_lo;
	logic [CW-1:0]    cur_hi;
	logic [CW-1:0]    span;
	logic [CW-1:0]    span_m1;
	logic [CW-1:0]    mid_n;
	logic [XW-1:0]    cnt_x;
	logic [XW-1:0]    end_x;
	logic [XW-1:0]    first_x;

	function automatic logic [POS_W-1:0] to_pos(input logic [CW-1:0] v);
		logic [XW-1:0] x;
		x = XW'(v);
		return x[POS_W-1:0];
	endfunction

	assign accept = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);
	assign full = (cnt_q >= CW'(DEPTH));
	assign wr_en = accept && (req.mode == MODE_APPEND) && !full;

	always_comb begin
		cnt_x = XW'(cnt_q);
		end_x = (XW'(req.range_end) < cnt_x) ? XW'(req.range_end) : cnt_x;
		first_x = (XW'(req.range_start) < end_x) ? XW'(req.range_start) : end_x;
	end

	assign key_lt = (key_rd < key_q);
	assign hit = (state_q == S_CMP) && (mode_q == MODE_FIND) && (key_rd == key_q);
	assign searching = (state_q == S_PROBE) || ((state_q == S_CMP) && !hit);

	always_comb begin
		cur_lo = lo_q;
		cur_hi = hi_q;
		if (state_q == S_CMP) begin
			if (key_lt) begin
				cur_lo = mid_q + CW'(1);
			end else begin
				cur_hi = mid_q;
			end
		end
		span = cur_hi - cur_lo;
		span_m1 = span - CW'(1);
		if (mode_q == MODE_FIND) begin
			mid_n = cur_lo + (span_m1 >> 1);
		end else begin
			mid_n = cur_lo + (span >> 1);
		end
		more = (cur_lo < cur_hi);
	end

	assign rd_en = searching && (more || ((mode_q == MODE_LOWER) && (cur_lo < cnt_q)));
	assign rd_addr = more ? mid_n[AW-1:0] : cur_lo[AW-1:0];

	sis_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_key_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(cnt_q[AW-1:0]),
		.wr_data(req.search_key),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(key_rd)
	);

	sis_ram #(
		.WIDTH(OFF_W),
		.DEPTH(DEPTH)
	) u_off_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(cnt_q[AW-1:0]),
		.wr_data(req.offset_value),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(off_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			mode_q <= MODE_APPEND;
			key_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			end_q <= '0;
			mid_q <= '0;
			res_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q <= req.mode;
						key_q <= req.search_key;
						case (req.mode)
							MODE_APPEND: begin
								if (full) begin
									res_q <= '{ST_FULL, to_pos(cnt_q), '0};
								end else begin
									cnt_q <= cnt_q + CW'(1);
									res_q <= '{ST_OK, to_pos(cnt_q + CW'(1)), '0};
								end
								state_q <= S_DONE;
							end
							MODE_CLEAR: begin
								cnt_q <= '0;
								res_q <= '{ST_OK, '0, '0};
								state_q <= S_DONE;
							end
							MODE_FIND: begin
								lo_q <= '0;
								hi_q <= cnt_q;
								end_q <= cnt_q;
								state_q <= S_PROBE;
							end
							default: begin
								lo_q <= first_x[CW-1:0];
								hi_q <= end_x[CW-1:0];
								end_q <= end_x[CW-1:0];
								state_q <= S_PROBE;
							end
						endcase
					end
				end
				S_PROBE, S_CMP: begin
					if (hit) begin
						res_q <= '{ST_OK, to_pos(mid_q), off_rd};
						state_q <= S_DONE;
					end else if (more) begin
						lo_q <= cur_lo;
						hi_q <= cur_hi;
						mid_q <= mid_n;
						state_q <= S_CMP;
					end else if (mode_q == MODE_FIND) begin
						res_q <= '{ST_MISS, '0, '0};
						state_q <= S_DONE;
					end else begin
						res_q.status <= (cur_lo < end_q) ? ST_OK : ST_MISS;
						res_q.position <= to_pos(cur_lo);
						res_q.stored_offset <= '0;
						if (cur_lo < cnt_q) begin
							state_q <= S_OFF;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_OFF: begin
					res_q.stored_offset <= off_rd;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (room) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = (state_q == S_DONE) && room;
	assign res = res_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count exceeds table depth");

	a_probe_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (mid_q < cnt_q))
		else $error("probe beyond written entries");

	a_probe_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ((lo_q <= mid_q) && (mid_q < hi_q)))
		else $error("probe outside search window");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted item did not start work");
`endif

endmodule

### src/sorted_index_search_top.sv
// Sorted index search top level: command sequencer plus result register.
// Depends on sis_pkg and sis_seq.
//
// Usage: the request channel (req_valid, req_stall, req) carries one command
// per item: append, clear, exact find or lower-bound search. The result
// channel (rsp_valid, rsp_stall, rsp) returns exactly one item per command,
// in command order. An item moves at a rising edge with valid high and
// stall low.
// Flow: append and clear go from acceptance to S_DONE and then into the
// output register that drives rsp. A search steps through S_PROBE, one
// S_CMP per probe of the key store, and S_DONE, with S_OFF before S_DONE
// when a lower-bound search reads the offset at its final position; a full
// 1024-entry table needs up to 11 probes. The next command is taken in the
// cycle after the result enters the output register.
// The key and offset stores share one read address and are probed once
// per cycle, which sets how long a search takes.
// Reset clears the entry count and empties the output register; the stores
// keep no valid state and are read only at positions written since the
// last clear. While the receiver stalls, the output register holds its
// item, and the sequencer may accept and finish one more command, then
// waits for the output register to free up.
module sorted_index_search_top import sis_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic out_valid_q;
	rsp_t out_q;
	logic room;
	logic done;
	rsp_t res;

	assign room = !out_valid_q || !rsp_stall;

	sis_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.room(room),
		.done(done),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
				out_q <= res;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

endmodule
